// ----- rtl/bv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bv_pkg
// Shared types and constants of the bencode validator.
// ----------------------------------------------------------------------------
package bv_pkg;

  localparam int MAX_NESTING = 32;
  localparam int LVL_W       = $clog2(MAX_NESTING + 1);

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0]  RST_STR_LEN_DIGITS = 5'd10;
  localparam logic [31:0] RST_STR_MAX_BYTES  = 32'd1048576;
  localparam logic [4:0]  RST_INT_DIGITS     = 5'd19;
  localparam logic [62:0] RST_INT_MAG        = {63{1'b1}};

  typedef enum logic [1:0] {
    CFG_STR_LEN_DIGITS = 2'd0,
    CFG_STR_MAX_BYTES  = 2'd1,
    CFG_INT_DIGITS     = 2'd2,
    CFG_INT_MAG        = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_VALID   = 2'd1,
    V_INVALID = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    NEST_NONE = 2'd0,
    NEST_LIST = 2'd1,
    NEST_DKEY = 2'd2,
    NEST_DVAL = 2'd3
  } nest_t;

  typedef enum logic [3:0] {
    PH_TOP     = 4'd0,
    PH_ITEM    = 4'd1,
    PH_KEY     = 4'd2,
    PH_DVAL    = 4'd3,
    PH_SLEN    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_ISTART  = 4'd6,
    PH_INEG    = 4'd7,
    PH_IDIG    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2,
    STK_SET  = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    nest_t   kind;
  } stk_cmd_t;

  typedef struct packed {
    logic [4:0]  str_len_max_digits;
    logic [31:0] str_max_bytes;
    logic [4:0]  int_max_digits;
    logic [62:0] int_max_magnitude;
  } cfg_t;

endpackage

// ----- rtl/bv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bv_if
// Valid/ready channel interfaces: input bytes, verdicts, register writes.
// ----------------------------------------------------------------------------
interface bv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface bv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       message_end;

  modport source (output valid, output verdict, output message_end, input ready);
  modport sink   (input valid, input verdict, input message_end, output ready);
endinterface

interface bv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bv_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bv_cell
// One nesting stack entry; shifts toward or away from the top on push/pop.
// ----------------------------------------------------------------------------
module bv_cell (
  input  logic            clk,
  input  bv_pkg::stk_op_t op,
  input  bv_pkg::nest_t   above,
  input  bv_pkg::nest_t   below,
  input  bv_pkg::nest_t   set_val,
  output bv_pkg::nest_t   q
);

  bv_pkg::nest_t q_r;
  bv_pkg::nest_t q_nxt;

  always_comb begin
    unique case (op)
      bv_pkg::STK_PUSH: q_nxt = above;
      bv_pkg::STK_POP:  q_nxt = below;
      bv_pkg::STK_SET:  q_nxt = set_val;
      default:          q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/bv_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bv_stack
// Nesting stack built as a row of shifting cells; cell 0 is the top.
// ----------------------------------------------------------------------------
module bv_stack (
  input  logic             clk,
  input  bv_pkg::stk_cmd_t cmd,
  output bv_pkg::nest_t    top_o,
  output bv_pkg::nest_t    next_o
);

  bv_pkg::nest_t cell_q [bv_pkg::MAX_NESTING];

  for (genvar i = 0; i < bv_pkg::MAX_NESTING; i++) begin : g_cell
    bv_pkg::stk_op_t cell_op;
    bv_pkg::nest_t   above;
    bv_pkg::nest_t   below;

    if (i == 0) begin : g_top
      // pop also rewrites the new top with the parent's next state
      assign cell_op = (cmd.op == bv_pkg::STK_POP) ? bv_pkg::STK_SET : cmd.op;
      assign above   = cmd.kind;
    end else begin : g_body
      assign cell_op = (cmd.op == bv_pkg::STK_SET) ? bv_pkg::STK_HOLD : cmd.op;
      assign above   = cell_q[i-1];
    end

    if (i == bv_pkg::MAX_NESTING - 1) begin : g_end
      assign below = cell_q[i];
    end else begin : g_mid
      assign below = cell_q[i+1];
    end

    bv_cell u_cell (
      .clk     (clk),
      .op      (cell_op),
      .above   (above),
      .below   (below),
      .set_val (cmd.kind),
      .q       (cell_q[i])
    );
  end

  assign top_o = cell_q[0];

  if (bv_pkg::MAX_NESTING > 1) begin : g_next
    assign next_o = cell_q[1];
  end else begin : g_next_one
    assign next_o = cell_q[0];
  end

endmodule

// ----- rtl/bv_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bv_parse
// Per-byte bencode parser: phase, nesting level, number and payload counters.
// ----------------------------------------------------------------------------
module bv_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  bv_pkg::cfg_t          cfg_i,
  input  bv_pkg::nest_t         top_i,
  input  bv_pkg::nest_t         next_i,
  output bv_pkg::stk_cmd_t      stk_cmd_o,
  output bv_pkg::verdict_t      verdict_o
);

  bv_pkg::phase_t             phase_r,  phase_nxt;
  logic [bv_pkg::LVL_W-1:0]   lvl_r,    lvl_nxt;
  logic [4:0]                 cnt_r,    cnt_nxt;
  logic [63:0]                acc_r,    acc_nxt;
  logic [31:0]                pay_r,    pay_nxt;
  bv_pkg::verdict_t           sticky_r, sticky_nxt;

  logic                       is_dig;
  logic [3:0]                 dval;
  logic                       fail, sv, cl, vd, tk, fresh, popped;
  logic [4:0]                 lim;
  logic [bv_pkg::LVL_W-1:0]   vd_lvl;
  bv_pkg::nest_t              vd_top;
  logic [4:0]                 cnt_base;
  logic [63:0]                acc_base;
  logic [67:0]                acc_mul;

  assign is_dig = (byte_i >= bv_pkg::CH_ZERO) && (byte_i <= bv_pkg::CH_NINE);
  assign dval   = 4'(byte_i - bv_pkg::CH_ZERO);

  always_comb begin
    phase_nxt  = phase_r;
    lvl_nxt    = lvl_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    pay_nxt    = pay_r;
    sticky_nxt = sticky_r;
    stk_cmd_o  = '{op: bv_pkg::STK_HOLD, kind: bv_pkg::NEST_NONE};
    fail       = 1'b0;
    sv         = 1'b0;
    cl         = 1'b0;
    vd         = 1'b0;
    tk         = 1'b0;
    fresh      = 1'b0;
    popped     = 1'b0;
    lim        = cfg_i.str_len_max_digits;
    vd_lvl     = lvl_r;
    vd_top     = top_i;
    cnt_base   = '0;
    acc_base   = '0;
    acc_mul    = '0;

    if (sticky_r == bv_pkg::V_PENDING) begin
      unique case (phase_r) inside
        bv_pkg::PH_TOP, bv_pkg::PH_DVAL: begin
          sv = 1'b1;
        end
        bv_pkg::PH_ITEM: begin
          if (byte_i == bv_pkg::CH_E) cl = 1'b1;
          else sv = 1'b1;
        end
        bv_pkg::PH_KEY: begin
          if (byte_i == bv_pkg::CH_E) begin
            cl = 1'b1;
          end else if (is_dig) begin
            fresh     = 1'b1;
            tk        = 1'b1;
            phase_nxt = bv_pkg::PH_SLEN;
          end else begin
            fail = 1'b1;
          end
        end
        bv_pkg::PH_SLEN: begin
          if (is_dig) begin
            tk = 1'b1;
          end else if (byte_i != bv_pkg::CH_COLON || cnt_r == '0 ||
                       acc_r > {32'b0, cfg_i.str_max_bytes}) begin
            fail = 1'b1;
          end else if (acc_r == '0) begin
            vd = 1'b1;
          end else begin
            pay_nxt   = acc_r[31:0];
            phase_nxt = bv_pkg::PH_PAYLOAD;
          end
        end
        bv_pkg::PH_PAYLOAD: begin
          pay_nxt = pay_r - 32'd1;
          if (pay_r == 32'd1) vd = 1'b1;
        end
        bv_pkg::PH_ISTART: begin
          if (byte_i == bv_pkg::CH_MINUS) begin
            phase_nxt = bv_pkg::PH_INEG;
          end else if (is_dig) begin
            phase_nxt = bv_pkg::PH_IDIG;
            tk        = 1'b1;
            lim       = cfg_i.int_max_digits;
          end else begin
            fail = 1'b1;
          end
        end
        bv_pkg::PH_INEG: begin
          if (is_dig) begin
            phase_nxt = bv_pkg::PH_IDIG;
            tk        = 1'b1;
            lim       = cfg_i.int_max_digits;
          end else begin
            fail = 1'b1;
          end
        end
        bv_pkg::PH_IDIG: begin
          if (is_dig) begin
            tk  = 1'b1;
            lim = cfg_i.int_max_digits;
          end else if (byte_i != bv_pkg::CH_E || cnt_r == '0 ||
                       acc_r > {1'b0, cfg_i.int_max_magnitude}) begin
            fail = 1'b1;
          end else begin
            vd = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase

      if (sv) begin
        if (byte_i == bv_pkg::CH_D || byte_i == bv_pkg::CH_L) begin
          if (lvl_r >= bv_pkg::LVL_W'(bv_pkg::MAX_NESTING)) begin
            fail = 1'b1;
          end else begin
            lvl_nxt      = lvl_r + 1'b1;
            stk_cmd_o.op = bv_pkg::STK_PUSH;
            if (byte_i == bv_pkg::CH_D) begin
              stk_cmd_o.kind = bv_pkg::NEST_DKEY;
              phase_nxt      = bv_pkg::PH_KEY;
            end else begin
              stk_cmd_o.kind = bv_pkg::NEST_LIST;
              phase_nxt      = bv_pkg::PH_ITEM;
            end
          end
        end else if (byte_i == bv_pkg::CH_I) begin
          fresh     = 1'b1;
          phase_nxt = bv_pkg::PH_ISTART;
        end else if (is_dig) begin
          fresh     = 1'b1;
          tk        = 1'b1;
          phase_nxt = bv_pkg::PH_SLEN;
        end else begin
          fail = 1'b1;
        end
      end

      if (cl) begin
        if (lvl_r == '0) begin
          fail = 1'b1;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
          vd_lvl  = lvl_r - 1'b1;
          vd_top  = next_i;
          popped  = 1'b1;
          vd      = 1'b1;
        end
      end

      if (vd) begin
        if (vd_lvl == '0) begin
          sticky_nxt = bv_pkg::V_VALID;
        end else begin
          case (vd_top)
            bv_pkg::NEST_LIST: begin
              phase_nxt      = bv_pkg::PH_ITEM;
              stk_cmd_o.kind = bv_pkg::NEST_LIST;
            end
            bv_pkg::NEST_DKEY: begin
              phase_nxt      = bv_pkg::PH_DVAL;
              stk_cmd_o.kind = bv_pkg::NEST_DVAL;
            end
            default: begin
              phase_nxt      = bv_pkg::PH_KEY;
              stk_cmd_o.kind = bv_pkg::NEST_DKEY;
            end
          endcase
        end
        if (popped) stk_cmd_o.op = bv_pkg::STK_POP;
        else if (vd_lvl != '0) stk_cmd_o.op = bv_pkg::STK_SET;
      end

      cnt_base = fresh ? 5'd0 : cnt_r;
      acc_base = fresh ? 64'd0 : acc_r;
      acc_mul  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + 68'(dval);
      if (fresh) begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      if (tk) begin
        if (cnt_base >= lim) begin
          fail = 1'b1;
        end else begin
          cnt_nxt = cnt_base + 5'd1;
          acc_nxt = (|acc_mul[67:64]) ? {64{1'b1}} : acc_mul[63:0];
        end
      end

      if (fail) sticky_nxt = bv_pkg::V_INVALID;
    end

    verdict_o = sticky_nxt;
    if (last_i && sticky_nxt == bv_pkg::V_PENDING) verdict_o = bv_pkg::V_INVALID;

    if (last_i) begin
      phase_nxt  = bv_pkg::PH_TOP;
      lvl_nxt    = '0;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      pay_nxt    = '0;
      sticky_nxt = bv_pkg::V_PENDING;
    end

    if (!acc_i) stk_cmd_o.op = bv_pkg::STK_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bv_pkg::PH_TOP;
      lvl_r    <= '0;
      cnt_r    <= '0;
      acc_r    <= '0;
      pay_r    <= '0;
      sticky_r <= bv_pkg::V_PENDING;
    end else if (acc_i) begin
      phase_r  <= phase_nxt;
      lvl_r    <= lvl_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      pay_r    <= pay_nxt;
      sticky_r <= sticky_nxt;
    end
  end

`ifndef SYNTHESIS
  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= bv_pkg::LVL_W'(bv_pkg::MAX_NESTING))
    else $error("nesting level above stack depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc_i && last_i |=> lvl_r == '0 && phase_r == bv_pkg::PH_TOP &&
                        sticky_r == bv_pkg::V_PENDING)
    else $error("state not cleared after last byte");

  a_invalid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r == bv_pkg::V_INVALID && !(acc_i && last_i) |=> sticky_r == bv_pkg::V_INVALID)
    else $error("invalid verdict dropped before message end");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bv_pkg::PH_PAYLOAD && sticky_r == bv_pkg::V_PENDING |-> pay_r != '0)
    else $error("payload phase with zero count");
`endif

endmodule

// ----- rtl/bencode_validator.sv -----
`timescale 1ns / 1ps
// A verdict appears in the output register in the cycle after its byte
// transaction. One byte is taken per cycle while the verdict output is not
// stalled; the parser state update and the shifting cell row of the nesting
// stack are both registered on each accepted byte. Reset clears the parser
// state and loads the register defaults; stack cells are not cleared and no
// clearing pass is needed. Register writes are always accepted.
// ----------------------------------------------------------------------------
// bencode_validator
// Streaming bencode validator with a per-byte verdict.
// ----------------------------------------------------------------------------
module bencode_validator (
  input  logic     clk,
  input  logic     rst_n,
  bv_in_if.sink    in_ch,
  bv_out_if.source out_ch,
  bv_cfg_if.sink   cfg_ch
);

  bv_pkg::cfg_t     cfg_r;
  bv_pkg::stk_cmd_t stk_cmd;
  bv_pkg::nest_t    stk_top;
  bv_pkg::nest_t    stk_next;
  bv_pkg::verdict_t res_verdict;
  logic             in_acc;
  logic             out_valid_r;
  bv_pkg::verdict_t out_verdict_r;
  logic             out_end_r;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.str_len_max_digits <= bv_pkg::RST_STR_LEN_DIGITS;
      cfg_r.str_max_bytes      <= bv_pkg::RST_STR_MAX_BYTES;
      cfg_r.int_max_digits     <= bv_pkg::RST_INT_DIGITS;
      cfg_r.int_max_magnitude  <= bv_pkg::RST_INT_MAG;
    end else if (cfg_ch.valid) begin
      unique case (bv_pkg::cfg_idx_t'(cfg_ch.index))
        bv_pkg::CFG_STR_LEN_DIGITS: cfg_r.str_len_max_digits <= cfg_ch.data[4:0];
        bv_pkg::CFG_STR_MAX_BYTES:  cfg_r.str_max_bytes      <= cfg_ch.data[31:0];
        bv_pkg::CFG_INT_DIGITS:     cfg_r.int_max_digits     <= cfg_ch.data[4:0];
        bv_pkg::CFG_INT_MAG:        cfg_r.int_max_magnitude  <= cfg_ch.data[62:0];
        default: ;
      endcase
    end
  end

  bv_stack u_stack (
    .clk    (clk),
    .cmd    (stk_cmd),
    .top_o  (stk_top),
    .next_o (stk_next)
  );

  bv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (in_acc),
    .byte_i    (in_ch.byte_in),
    .last_i    (in_ch.last_byte),
    .cfg_i     (cfg_r),
    .top_i     (stk_top),
    .next_i    (stk_next),
    .stk_cmd_o (stk_cmd),
    .verdict_o (res_verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_verdict_r <= res_verdict;
      out_end_r     <= in_ch.last_byte;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_verdict_r;
  assign out_ch.message_end = out_end_r;

endmodule

// ----- dv/bencode_validator_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_validator_chk
// Watches the byte, verdict and register channels of the bencode validator.
// Keeps its own copy of the parser and register state, predicts one verdict
// per accepted byte and compares each verdict transaction against the
// oldest prediction.
// ----------------------------------------------------------------------------
module bencode_validator_chk import bv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bv_in_if            in_ch,
  bv_out_if           out_ch,
  bv_cfg_if           cfg_ch,
  output int unsigned fail_cnt,
  output int unsigned verdicts_waiting,
  output int unsigned msgs_valid,
  output int unsigned msgs_invalid
);

  localparam int unsigned MAX_REPORTS = 30;

  typedef struct packed {
    verdict_t verdict;
    logic     msg_end;
  } verdict_exp_t;

  verdict_exp_t verdicts_due [$];
  int unsigned  verdicts_seen;

  cfg_t         regs;
  nest_t        stack_q [MAX_NESTING];
  int unsigned  level;
  phase_t       phase;
  int unsigned  ndig;
  logic [63:0]  accum;
  logic [31:0]  left;
  verdict_t     sticky;

  task automatic report(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%0t ns: verdict #%0d: %s", $time, verdicts_seen, msg);
  endtask

  function automatic void clear_parse();
    level  = 0;
    phase  = PH_TOP;
    ndig   = 0;
    accum  = '0;
    left   = '0;
    sticky = V_PENDING;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit add_digit(logic [7:0] b, logic [4:0] lim);
    logic [63:0] d;
    d = 64'(b - CH_ZERO);
    if (ndig >= lim) return 1'b0;
    ndig++;
    // saturate rather than wrap
    if (accum > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) accum = '1;
    else accum = accum * 64'd10 + d;
    return 1'b1;
  endfunction

  function automatic void begin_number(phase_t p);
    phase = p;
    ndig  = 0;
    accum = '0;
  endfunction

  function automatic void finish_value();
    if (level == 0) begin
      sticky = V_VALID;
      return;
    end
    case (stack_q[level-1])
      NEST_LIST: phase = PH_ITEM;
      NEST_DKEY: begin
        stack_q[level-1] = NEST_DVAL;
        phase = PH_DVAL;
      end
      default: begin
        stack_q[level-1] = NEST_DKEY;
        phase = PH_KEY;
      end
    endcase
  endfunction

  function automatic bit open_container(nest_t kind, phase_t p);
    if (level >= MAX_NESTING) return 1'b0;
    stack_q[level] = kind;
    level++;
    phase = p;
    return 1'b1;
  endfunction

  function automatic bit close_container();
    if (level == 0) return 1'b0;
    level--;
    finish_value();
    return 1'b1;
  endfunction

  function automatic bit begin_string(logic [7:0] b);
    begin_number(PH_SLEN);
    return add_digit(b, regs.str_len_max_digits);
  endfunction

  function automatic bit begin_value(logic [7:0] b);
    if (b == CH_D) return open_container(NEST_DKEY, PH_KEY);
    if (b == CH_L) return open_container(NEST_LIST, PH_ITEM);
    if (b == CH_I) begin
      begin_number(PH_ISTART);
      return 1'b1;
    end
    if (is_digit(b)) return begin_string(b);
    return 1'b0;
  endfunction

  // returns 0 when the byte breaks the message
  function automatic bit scan_byte(logic [7:0] b);
    case (phase)
      PH_TOP, PH_DVAL: return begin_value(b);
      PH_ITEM: begin
        if (b == CH_E) return close_container();
        return begin_value(b);
      end
      PH_KEY: begin
        if (b == CH_E) return close_container();
        if (is_digit(b)) return begin_string(b);
        return 1'b0;
      end
      PH_SLEN: begin
        if (is_digit(b)) return add_digit(b, regs.str_len_max_digits);
        if (b != CH_COLON || ndig == 0) return 1'b0;
        if (accum > {32'd0, regs.str_max_bytes}) return 1'b0;
        if (accum == 0) finish_value();
        else begin
          left  = accum[31:0];
          phase = PH_PAYLOAD;
        end
        return 1'b1;
      end
      PH_PAYLOAD: begin
        left--;
        if (left == 0) finish_value();
        return 1'b1;
      end
      PH_ISTART: begin
        if (b == CH_MINUS) begin
          phase = PH_INEG;
          return 1'b1;
        end
        if (!is_digit(b)) return 1'b0;
        phase = PH_IDIG;
        return add_digit(b, regs.int_max_digits);
      end
      PH_INEG: begin
        if (!is_digit(b)) return 1'b0;
        phase = PH_IDIG;
        return add_digit(b, regs.int_max_digits);
      end
      PH_IDIG: begin
        if (is_digit(b)) return add_digit(b, regs.int_max_digits);
        if (b != CH_E || ndig == 0) return 1'b0;
        if (accum > {1'b0, regs.int_max_magnitude}) return 1'b0;
        finish_value();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic verdict_exp_t predict_verdict(logic [7:0] b, logic last);
    verdict_exp_t r;
    if (sticky == V_PENDING) begin
      if (!scan_byte(b)) sticky = V_INVALID;
    end
    r.verdict = sticky;
    if (last && r.verdict == V_PENDING) r.verdict = V_INVALID;
    r.msg_end = last;
    if (last) clear_parse();
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_exp_t exp_v;
    if (!rst_n) begin
      clear_parse();
      regs = '{RST_STR_LEN_DIGITS, RST_STR_MAX_BYTES, RST_INT_DIGITS, RST_INT_MAG};
      verdicts_due.delete();
      verdicts_seen = 0;
      fail_cnt      = 0;
      msgs_valid    = 0;
      msgs_invalid  = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_STR_LEN_DIGITS: regs.str_len_max_digits = cfg_ch.data[4:0];
          CFG_STR_MAX_BYTES:  regs.str_max_bytes      = cfg_ch.data[31:0];
          CFG_INT_DIGITS:     regs.int_max_digits     = cfg_ch.data[4:0];
          CFG_INT_MAG:        regs.int_max_magnitude  = cfg_ch.data[62:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        verdicts_due.push_back(predict_verdict(in_ch.byte_in, in_ch.last_byte));
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          report("verdict transaction with no byte outstanding");
        end else begin
          exp_v = verdicts_due.pop_front();
          if (out_ch.verdict !== exp_v.verdict)
            report($sformatf("verdict %0d, expected %s", out_ch.verdict, exp_v.verdict.name()));
          if (out_ch.message_end !== exp_v.msg_end)
            report($sformatf("message_end %b, expected %b", out_ch.message_end, exp_v.msg_end));
          if (exp_v.msg_end) begin
            if (exp_v.verdict == V_VALID) msgs_valid++;
            else msgs_invalid++;
          end
        end
      end
    end
    verdicts_waiting = verdicts_due.size();
  end

endmodule

// ----- dv/bencode_validator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_validator_tb
// Drives bencoded messages byte by byte into the validator under several
// register settings: hand-picked edge cases first, then random well-formed,
// mutated, truncated and noise messages, with random idling on both sides
// and one long output stall. The checker predicts and compares verdicts.
// ----------------------------------------------------------------------------
module bencode_validator_tb;
  import bv_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef logic [7:0] msg_t [$];

  logic clk;
  logic rst_n;

  bv_in_if  in_if ();
  bv_out_if out_if ();
  bv_cfg_if cfg_if ();

  int unsigned fail_cnt, verdicts_waiting, msgs_valid, msgs_invalid;
  int unsigned bytes_sent, msgs_sent, settings_used, idle_cycles, stall_at;
  bit          calm, hold_req;
  cfg_t        cur_cfg;

  string dflt_cases [$] = '{
    "i0e", "i-0e", "i007e", "ie", "i-e", "i", "0:", ":", "4:spam", "le", "de",
    "d3:key5:valuee", "di1ei2ee", "d1:ae", "e", "x", "xi1e", "i1exyz", "li1e",
    "l4:abcdi3ee", "d1:ad1:bli-5eeee", "i9223372036854775807e",
    "i-9223372036854775808e", "i12345678901234567890e", "12345678901:",
    "1048577:", "1048576:ab", "4:sp", "i12", "12"
  };
  string min_cases [$] = '{"i0e", "i-0e", "i1e", "i00e", "0:", "1:a", "10:", "le"};
  string max_cases [$] = '{
    "4294967295:ab", "4294967296:", "0000000000000000004:abcd",
    "00000000000000000004:", "i0000000000000000001e", "i10000000000000000000e"
  };

  bencode_validator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bencode_validator_chk chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_if),
    .out_ch           (out_if),
    .cfg_ch           (cfg_if),
    .fail_cnt         (fail_cnt),
    .verdicts_waiting (verdicts_waiting),
    .msgs_valid       (msgs_valid),
    .msgs_invalid     (msgs_invalid)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // verdict sink: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned n;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = calm ? 0 : pick_gap();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  function automatic int unsigned lead_zeros();
    return ($urandom_range(0, 7) == 0) ? 1 : 0;
  endfunction

  function automatic void put_dec(ref msg_t m, input logic [63:0] v, input int unsigned pad);
    logic [7:0] digs [$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    repeat (pad) m.push_back(CH_ZERO);
    foreach (digs[i]) m.push_back(digs[i]);
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(0, 19))
      0: return {32'd0, cur_cfg.str_max_bytes};
      1: return {32'd0, cur_cfg.str_max_bytes} + 64'd1;
      default: return 64'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [63:0] rand_mag();
    case ($urandom_range(0, 9))
      0: return {1'b0, cur_cfg.int_max_magnitude};
      1: return {1'b0, cur_cfg.int_max_magnitude} + 64'd1;
      2: return {1'b0, 63'({$urandom, $urandom})};
      default: return 64'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0: return CH_I;
      1: return CH_L;
      2: return CH_D;
      3: return CH_E;
      4: return CH_MINUS;
      5: return CH_COLON;
      6: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // long strings only get a short piece of payload and end up truncated
  function automatic void put_str(ref msg_t m, input logic [63:0] len);
    put_dec(m, len, lead_zeros());
    m.push_back(CH_COLON);
    for (logic [63:0] i = 0; i < len && i < 12; i++) m.push_back(8'($urandom));
  endfunction

  function automatic void put_value(ref msg_t m, input int unsigned depth);
    int unsigned kind, n;
    kind = (depth >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    n = $urandom_range(0, 3);
    case (kind)
      0: begin
        m.push_back(CH_I);
        if ($urandom_range(0, 1)) m.push_back(CH_MINUS);
        put_dec(m, rand_mag(), lead_zeros());
        m.push_back(CH_E);
      end
      1: put_str(m, rand_len());
      2: begin
        m.push_back(CH_L);
        repeat (n) put_value(m, depth + 1);
        m.push_back(CH_E);
      end
      default: begin
        m.push_back(CH_D);
        repeat (n) begin
          put_str(m, rand_len());
          put_value(m, depth + 1);
        end
        m.push_back(CH_E);
      end
    endcase
  endfunction

  // mostly well-formed values; some mutated, truncated, deeply nested or noise
  function automatic void build_message(ref msg_t m);
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      n = $urandom_range(MAX_NESTING - 4, MAX_NESTING + 2);
      repeat (n) m.push_back(CH_L);
      put_value(m, 3);
      repeat (n) m.push_back(CH_E);
    end else if (r < 90) begin
      put_value(m, 0);
      if (r >= 65 && r < 80) begin
        m[$urandom_range(0, m.size() - 1)] = pick_char();
      end else if (r >= 80 && m.size() > 1) begin
        repeat ($urandom_range(1, m.size() - 1)) void'(m.pop_back());
      end
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) m.push_back(pick_char());
    end else begin
      repeat ($urandom_range(1, 8)) m.push_back(pick_char());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    bit took;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.byte_in   <= b;
    in_if.last_byte <= last;
    do begin
      @(negedge clk);
      took = in_if.ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_msg(msg_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    msgs_sent++;
  endtask

  task automatic send_text(string s);
    msg_t m;
    foreach (s[i]) m.push_back(s[i]);
    send_msg(m);
  endtask

  task automatic send_nest(int unsigned depth);
    msg_t m;
    repeat (depth) m.push_back(CH_L);
    repeat (depth) m.push_back(CH_E);
    send_msg(m);
  endtask

  task automatic run_random(int unsigned goal);
    msg_t m;
    while (bytes_sent < goal) begin
      if (stall_at != 0 && bytes_sent >= stall_at) begin
        hold_req = 1'b1;
        stall_at = 0;
      end
      m.delete();
      calm = ($urandom_range(0, 4) == 0);
      build_message(m);
      send_msg(m);
    end
    calm = 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (verdicts_waiting != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
    bit took;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits carry junk; the block must ignore them
  function automatic logic [63:0] with_junk(logic [63:0] v, int unsigned w);
    return ({$urandom, $urandom} << w) | v;
  endfunction

  task automatic apply_cfg(cfg_t c);
    write_reg(CFG_STR_LEN_DIGITS, with_junk(64'(c.str_len_max_digits), 5));
    write_reg(CFG_STR_MAX_BYTES, with_junk(64'(c.str_max_bytes), 32));
    write_reg(CFG_INT_DIGITS, with_junk(64'(c.int_max_digits), 5));
    write_reg(CFG_INT_MAG, with_junk(64'(c.int_max_magnitude), 63));
    cur_cfg = c;
    settings_used++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.str_len_max_digits = 5'($urandom_range(1, 19));
    c.int_max_digits     = 5'($urandom_range(1, 19));
    case ($urandom_range(0, 2))
      0: c.str_max_bytes = 32'($urandom_range(0, 8));
      1: c.str_max_bytes = $urandom;
      default: c.str_max_bytes = 32'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 2))
      0: c.int_max_magnitude = 63'($urandom_range(0, 99));
      1: c.int_max_magnitude = 63'({$urandom, $urandom});
      default: c.int_max_magnitude = 63'($urandom_range(0, 99999));
    endcase
    return c;
  endfunction

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.byte_in    <= '0;
    in_if.last_byte  <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_STR_LEN_DIGITS;
    cfg_if.data      <= '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    stall_at         = 0;
    bytes_sent       = 0;
    msgs_sent        = 0;
    settings_used    = 1;
    cur_cfg = '{RST_STR_LEN_DIGITS, RST_STR_MAX_BYTES, RST_INT_DIGITS, RST_INT_MAG};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults
    foreach (dflt_cases[i]) send_text(dflt_cases[i]);
    send_nest(MAX_NESTING);
    send_nest(MAX_NESTING + 1);
    send_byte(8'hFF, 1'b1);
    stall_at = bytes_sent + 200;
    run_random(bytes_sent + 400);
    drain();

    // tightest limits
    apply_cfg('{5'd1, 32'd0, 5'd1, 63'd0});
    foreach (min_cases[i]) send_text(min_cases[i]);
    run_random(bytes_sent + 60);
    drain();

    // loosest limits
    apply_cfg('{5'd19, 32'hFFFF_FFFF, 5'd19, {63{1'b1}}});
    foreach (max_cases[i]) send_text(max_cases[i]);
    run_random(bytes_sent + 150);
    drain();

    apply_cfg('{5'd3, 32'd20, 5'd4, 63'd1000});
    run_random(bytes_sent + 160);
    drain();

    repeat (2) begin
      apply_cfg(random_cfg());
      run_random(bytes_sent + 100);
      drain();
    end

    $display("Sent %0d bytes in %0d messages under %0d register settings,",
             bytes_sent, msgs_sent, settings_used);
    $display("with a %0d-cycle verdict stall; %0d valid and %0d invalid messages, %0d mismatches.",
             HOLD_CYCLES, msgs_valid, msgs_invalid, fail_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bv_pkg.sv
rtl/bv_if.sv
rtl/bv_cell.sv
rtl/bv_stack.sv
rtl/bv_parse.sv
rtl/bencode_validator.sv
dv/bencode_validator_chk.sv
dv/bencode_validator_tb.sv
